### hw/rtl/multiplexed_segment_display_scanner_top_macros.svh
// Assertion macros shared by the display scanner RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef MULTIPLEXED_SEGMENT_DISPLAY_SCANNER_TOP_MACROS_SVH
`define MULTIPLEXED_SEGMENT_DISPLAY_SCANNER_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define MDSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MDSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MDSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define MDSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/mdss_pkg.sv
// Shared types, codes and constants of the display scanner.
// No dependencies; imported by every module of the block.
`default_nettype none

package mdss_pkg;

  // Fixed field widths.
  localparam int unsigned SEG_W       = 7;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned BRIGHT_W    = 4;

  // Number of digits; the digit field of a request is two bits wide, so at most four.
  localparam int unsigned DIGITS          = 4;
  // Brightness limit; this value disables blanking.
  localparam int unsigned FULL_BRIGHTNESS = 15;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0]    REFRESH_RST = 16'd1;
  localparam logic [CFG_W-1:0]    BLINK_RST   = 16'd250;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RST  = 4'd15;

  // Request function codes.
  typedef enum logic [2:0] {
    FN_TICK        = 3'd0,
    FN_WRITE_SEG   = 3'd1,
    FN_WRITE_DOT   = 3'd2,
    FN_BLINK_START = 3'd3,
    FN_BLINK_STOP  = 3'd4
  } func_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_REFRESH = 2'd0,
    CFG_BLINK   = 2'd1,
    CFG_BRIGHT  = 2'd2
  } cfg_reg_e;

  // One request as held in the input register.
  typedef struct packed {
    logic [2:0]       func;
    logic [1:0]       digit;
    logic [SEG_W-1:0] segments;
    logic             dot;
  } item_t;

  // One result: pin state after the request plus the scan flag.
  typedef struct packed {
    logic [1:0]       select;
    logic [SEG_W-1:0] segments;
    logic             dot;
    logic             scan;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/multiplexed_segment_display_scanner_top.sv
// Multiplexed seven-segment display scanner. Each request (tick, segment write,
// dot write, blink start, blink stop) is taken into an input register, applied to
// the display state and its result (select, segment and dot pins, scan flag)
// lands in a result register. One request per clock is sustained while results
// are accepted; a stalled result holds the pipeline only once both the input and
// result registers are full. There is no clearing pass after reset. The user must
// write configuration through the plain write port only while no request is in
// flight; the block leaves this unchecked.
`default_nettype none

module multiplexed_segment_display_scanner_top import mdss_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [2:0]       func_i,
  input  wire logic [1:0]       digit_i,
  input  wire logic [SEG_W-1:0] segments_i,
  input  wire logic             dot_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            digit_select_o,
  output logic [SEG_W-1:0]      segment_drive_o,
  output logic                  dot_drive_o,
  output logic                  scan_event_o
);

  item_t in_item;
  item_t held_item;
  logic  held_valid;
  logic  out_free;
  logic  take;
  res_t  core_result;
  res_t  out_result;

  assign in_item.func     = func_i;
  assign in_item.digit    = digit_i;
  assign in_item.segments = segments_i;
  assign in_item.dot      = dot_i;

  // The core consumes the held request when the result register has room.
  assign take = held_valid && out_free;

  mdss_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (take),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  mdss_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .item_i      (held_item),
    .result_o    (core_result)
  );

  mdss_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .result_i    (core_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign digit_select_o  = out_result.select;
  assign segment_drive_o = out_result.segments;
  assign dot_drive_o     = out_result.dot;
  assign scan_event_o    = out_result.scan;

endmodule

`default_nettype wire

### hw/rtl/mdss_in_reg.sv
// Input register of the display scanner: holds one request for the core.
// Depends on mdss_pkg.
`default_nettype none

module mdss_in_reg import mdss_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire item_t item_i,
  input  wire logic  take_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q;
  item_t item_q;

  // Free when empty or when the held request is consumed this cycle.
  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload, loaded on acceptance.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mdss_core.sv
// Scanner core: configuration, display state and the per-request update.
// Depends on mdss_pkg and the assertion macro header.
`default_nettype none
`include "multiplexed_segment_display_scanner_top_macros.svh"

module mdss_core import mdss_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  input  wire logic             take_i,
  input  wire item_t            item_i,
  output res_t                  result_o
);

  localparam int unsigned IDXW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // Configuration registers.
  logic [CFG_W-1:0]    refresh_period_q, refresh_period_d;
  logic [CFG_W-1:0]    blink_period_q, blink_period_d;
  logic [BRIGHT_W-1:0] brightness_q, brightness_d;

  // Display state.
  logic [IDXW-1:0]     scan_index_q, scan_index_d;
  logic [CFG_W-1:0]    refresh_count_q, refresh_count_d;
  logic [CFG_W-1:0]    blink_count_q, blink_count_d;
  logic [BRIGHT_W-1:0] dim_count_q, dim_count_d;
  logic                fresh_q, fresh_d;
  logic [SEG_W-1:0]    seg_store_q [DIGITS];
  logic [SEG_W-1:0]    seg_store_d [DIGITS];
  logic [DIGITS-1:0]   dot_store_q, dot_store_d;
  logic [DIGITS-1:0]   enabled_q, enabled_d;
  logic                blink_active_q, blink_active_d;
  logic [1:0]          blink_target_q, blink_target_d;
  logic [1:0]          pin_select_q, pin_select_d;
  logic [SEG_W-1:0]    pin_segments_q, pin_segments_d;
  logic                pin_dot_q, pin_dot_d;

  logic                scan;
  logic [IDXW-1:0]     cur;
  logic                digit_ok;
  logic                full;
  logic [IDXW-1:0]     widx;

  // Request decode and state update.
  always_comb begin
    refresh_period_d = refresh_period_q;
    blink_period_d   = blink_period_q;
    brightness_d     = brightness_q;
    scan_index_d     = scan_index_q;
    refresh_count_d  = refresh_count_q;
    blink_count_d    = blink_count_q;
    dim_count_d      = dim_count_q;
    fresh_d          = fresh_q;
    seg_store_d      = seg_store_q;
    dot_store_d      = dot_store_q;
    enabled_d        = enabled_q;
    blink_active_d   = blink_active_q;
    blink_target_d   = blink_target_q;
    pin_select_d     = pin_select_q;
    pin_segments_d   = pin_segments_q;
    pin_dot_d        = pin_dot_q;
    scan             = 1'b0;

    cur      = (32'(scan_index_q) >= DIGITS) ? '0 : scan_index_q;
    digit_ok = (5'(item_i.digit) < 5'(DIGITS));
    widx     = IDXW'(item_i.digit);
    full     = (8'(brightness_q) == 8'(FULL_BRIGHTNESS));

    // Configuration writes must arrive only while no request is in flight; the core leaves this to the user.
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_REFRESH: refresh_period_d = cfg_wdata_i;
        CFG_BLINK:   blink_period_d   = cfg_wdata_i;
        CFG_BRIGHT: begin
          if (cfg_wdata_i[BRIGHT_W-1:0] != '0 &&
              8'(cfg_wdata_i[BRIGHT_W-1:0]) <= 8'(FULL_BRIGHTNESS)) begin
            brightness_d = cfg_wdata_i[BRIGHT_W-1:0];
          end
        end
        default: ;
      endcase
    end

    if (take_i) begin
      case (func_e'(item_i.func))
        FN_TICK: begin
          // Scan: step to the next digit when the refresh counter runs out.
          if (refresh_count_q != '0) begin
            refresh_count_d = refresh_count_q - 16'd1;
          end else begin
            pin_select_d    = 2'(cur);
            pin_segments_d  = enabled_q[cur] ? seg_store_q[cur] : '0;
            pin_dot_d       = dot_store_q[cur];
            scan_index_d    = (cur == IDXW'(DIGITS - 1)) ? '0 : cur + IDXW'(1);
            refresh_count_d = refresh_period_q;
            fresh_d         = 1'b1;
            scan            = 1'b1;
          end
          // Blink: toggle the target digit when the blink counter runs out.
          if (!blink_active_q) begin
            enabled_d = '1;
          end else if (blink_count_q != '0) begin
            blink_count_d = blink_count_q - 16'd1;
          end else begin
            for (int k = 0; k < DIGITS; k++) begin
              enabled_d[k] = (k == int'(blink_target_q)) ? ~enabled_q[k] : 1'b1;
            end
            blink_count_d = blink_period_q;
          end
          // Dimming: below full brightness, blank the pins once the dim count after a scan reaches the brightness.
          if (!full && fresh_d) begin
            if (dim_count_q >= brightness_q) begin
              pin_segments_d = '0;
              pin_dot_d      = 1'b0;
              fresh_d        = 1'b0;
              dim_count_d    = '0;
            end else begin
              dim_count_d = dim_count_q + 4'd1;
            end
          end
        end
        FN_WRITE_SEG: begin
          if (digit_ok) begin
            seg_store_d[widx] = item_i.segments;
          end
        end
        FN_WRITE_DOT: begin
          if (digit_ok) begin
            dot_store_d[widx] = item_i.dot;
          end
        end
        FN_BLINK_START: begin
          if (!blink_active_q) begin
            enabled_d = '1;
          end
          if (digit_ok) begin
            blink_target_d = item_i.digit;
            blink_active_d = 1'b1;
          end
        end
        FN_BLINK_STOP: begin
          blink_active_d = 1'b0;
          enabled_d      = '1;
        end
        default: ;
      endcase
    end

    result_o.select   = pin_select_d;
    result_o.segments = pin_segments_d;
    result_o.dot      = pin_dot_d;
    result_o.scan     = scan;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_period_q <= REFRESH_RST;
      blink_period_q   <= BLINK_RST;
      brightness_q     <= BRIGHT_RST;
      scan_index_q     <= '0;
      refresh_count_q  <= REFRESH_RST;
      blink_count_q    <= BLINK_RST;
      dim_count_q      <= '0;
      fresh_q          <= 1'b0;
      for (int k = 0; k < DIGITS; k++) begin
        seg_store_q[k] <= '0;
      end
      dot_store_q      <= '0;
      enabled_q        <= '1;
      blink_active_q   <= 1'b0;
      blink_target_q   <= '0;
      pin_select_q     <= '0;
      pin_segments_q   <= '1;
      pin_dot_q        <= 1'b1;
    end else begin
      refresh_period_q <= refresh_period_d;
      blink_period_q   <= blink_period_d;
      brightness_q     <= brightness_d;
      scan_index_q     <= scan_index_d;
      refresh_count_q  <= refresh_count_d;
      blink_count_q    <= blink_count_d;
      dim_count_q      <= dim_count_d;
      fresh_q          <= fresh_d;
      seg_store_q      <= seg_store_d;
      dot_store_q      <= dot_store_d;
      enabled_q        <= enabled_d;
      blink_active_q   <= blink_active_d;
      blink_target_q   <= blink_target_d;
      pin_select_q     <= pin_select_d;
      pin_segments_q   <= pin_segments_d;
      pin_dot_q        <= pin_dot_d;
    end
  end

  // Without an active blink every digit stays enabled.
  `MDSS_ASSERT_NOW(a_enabled_idle, clk_i, rst_ni, !blink_active_q, &enabled_q,
                   "digit disabled without blink")
  // The scan index never leaves the digit range.
  `MDSS_ASSERT_NOW(a_index_range, clk_i, rst_ni, 1'b1, 32'(scan_index_q) < DIGITS,
                   "scan index out of range")
  // A scan reloads the refresh counter from its period.
  `MDSS_ASSERT_NEXT(a_refresh_reload, clk_i, rst_ni,
                    take_i && item_i.func == FN_TICK && refresh_count_q == '0,
                    refresh_count_q == $past(refresh_period_q),
                    "refresh counter not reloaded")
  // Requests other than a tick leave the pins alone.
  `MDSS_ASSERT_NEXT(a_pins_hold, clk_i, rst_ni, take_i && item_i.func != FN_TICK,
                    $stable(pin_select_q) && $stable(pin_segments_q) && $stable(pin_dot_q),
                    "pins changed on a non-tick request")

endmodule

`default_nettype wire

### hw/rtl/mdss_out_reg.sv
// Result register of the display scanner with its valid flag.
// Depends on mdss_pkg.
`default_nettype none

module mdss_out_reg import mdss_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire res_t result_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      result_o
);

  logic valid_q;
  res_t result_q;

  // Room for a new result when empty or when the held one leaves now.
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire
